// ===== hdl/pec_pkg.sv =====
// Shared types and constants for the polygon edge crossing test.
// Used by pec_front, pec_back, polygon_edge_crossing_test and the testbench top.
package pec_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_WIDTH_DEF  = 16;

    // Command kinds passed from the front end to the test engine
    typedef enum logic [1:0] {
        CMD_FIRST,
        CMD_SECOND,
        CMD_TEST
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_DIFF,
        ST_MUL,
        ST_SUM,
        ST_DECIDE,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/pec_front.sv =====
// Front end: accepts vertex transactions, reduces coordinates and classifies them.
// Depends on pec_pkg.
module pec_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [31:0]             s_tdata,   // x [15:0], y [31:16]
    input  logic                    s_tuser,   // func
    input  logic                    s_tlast,
    output logic                    push_valid,
    input  logic                    push_ready,
    output logic [2*COORD_WIDTH+pec_pkg::CMD_W-1:0] push_data
);
    import pec_pkg::*;

    logic signed [15:0]          x_in;
    logic signed [15:0]          y_in;
    logic signed [COORD_WIDTH-1:0] x_red;
    logic signed [COORD_WIDTH-1:0] y_red;
    cmd_t                        kind;

    assign x_in = s_tdata[15:0];
    assign y_in = s_tdata[31:16];
    // wrap or sign-extend to the working coordinate width
    assign x_red = COORD_WIDTH'(x_in);
    assign y_red = COORD_WIDTH'(y_in);

    always_comb begin
        if (!s_tuser) begin
            kind = CMD_FIRST;
        end else if (s_tlast) begin
            kind = CMD_TEST;
        end else begin
            kind = CMD_SECOND;
        end
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;
    assign push_data  = {y_red, x_red, kind};

endmodule

// ===== hdl/pec_queue.sv =====
// Two-entry queue decoupling the front end from the test engine.
// Depends on pec_pkg only through the width handed down.
module pec_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/pec_back.sv =====
// Test engine: vertex stores, edge-pair sequencer and cross-product datapath.
// Depends on pec_pkg.
module pec_back #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  logic [2*COORD_WIDTH+pec_pkg::CMD_W-1:0] pop_data,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata     // crossing [0], overflow [1]
);
    import pec_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int D     = CW + 1;
    localparam int P     = 2 * D;
    localparam int S     = P + 1;

    function automatic logic [D-1:0] abs_d(input logic signed [D-1:0] v);
        abs_d = v[D-1] ? D'(-v) : D'(v);
    endfunction

    // queue entry
    cmd_t                   cmd_kind;
    logic [2*CW-1:0]        cmd_xy;

    state_t state_reg, state_next;

    logic [2*CW-1:0] first_mem  [MAX_VERTICES];
    logic [2*CW-1:0] second_mem [MAX_VERTICES];

    logic [CNT_W-1:0] fc_reg, sc_reg;
    logic [IDX_W-1:0] i_reg, j_reg;
    logic             ovf_reg, hit_reg;
    logic             out_valid_reg, out_cross_reg, out_ovf_reg;

    logic             pop_en, rd_en, take;
    logic [CNT_W-1:0] i_inc, j_inc;
    logic [IDX_W-1:0] in_idx, jn_idx;
    logic             j_more, i_more;
    logic             edge_hit;

    logic [2*CW-1:0]  p_reg, pn_reg, q_reg, qn_reg;
    logic signed [CW-1:0] px, py, pnx, pny, qx, qy, qnx, qny;

    logic signed [D-1:0] rx_reg, ry_reg, sx_reg, sy_reg, dqx_reg, dqy_reg;
    logic signed [P-1:0] m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic [D:0]          magx_reg, magy_reg;
    logic signed [S-1:0] a_reg, b_reg, c_reg;
    logic signed [CW-1:0] lo_r_reg, hi_r_reg, lo_s_reg, hi_s_reg;
    logic signed [CW-1:0] r0, r1, s0, s1, lo_max, hi_min;

    assign cmd_kind = cmd_t'(pop_data[CMD_W-1:0]);
    assign cmd_xy   = pop_data[2*CW+CMD_W-1:CMD_W];

    assign px  = p_reg[CW-1:0];
    assign py  = p_reg[2*CW-1:CW];
    assign pnx = pn_reg[CW-1:0];
    assign pny = pn_reg[2*CW-1:CW];
    assign qx  = q_reg[CW-1:0];
    assign qy  = q_reg[2*CW-1:CW];
    assign qnx = qn_reg[CW-1:0];
    assign qny = qn_reg[2*CW-1:CW];

    // closing edge wraps back to vertex zero
    assign i_inc  = CNT_W'(i_reg) + CNT_W'(1);
    assign j_inc  = CNT_W'(j_reg) + CNT_W'(1);
    assign i_more = (i_inc < fc_reg);
    assign j_more = (j_inc < sc_reg);
    assign in_idx = i_more ? i_inc[IDX_W-1:0] : '0;
    assign jn_idx = j_more ? j_inc[IDX_W-1:0] : '0;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take && cmd_kind == CMD_TEST) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (fc_reg == '0 || sc_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_SUM;
            ST_SUM:    state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (edge_hit || (!j_more && !i_more)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        pop_en = 1'b0;
        rd_en  = 1'b0;
        case (state_reg)
            ST_IDLE: pop_en = (cmd_kind != CMD_TEST) || !out_valid_reg;
            ST_READ: rd_en  = 1'b1;
            default: begin
                pop_en = 1'b0;
                rd_en  = 1'b0;
            end
        endcase
    end

    assign pop_ready = pop_en;
    assign take      = pop_valid && pop_en;

    // edge pair decision
    assign lo_max = (lo_r_reg > lo_s_reg) ? lo_r_reg : lo_s_reg;
    assign hi_min = (hi_r_reg < hi_s_reg) ? hi_r_reg : hi_s_reg;

    always_comb begin
        if (a_reg == '0) begin
            edge_hit = (b_reg != '0 && c_reg != '0) ? 1'b0 : (lo_max < hi_min);
        end else if (a_reg > 0) begin
            edge_hit = b_reg >= 0 && b_reg <= a_reg && c_reg >= 0 && c_reg <= a_reg;
        end else begin
            edge_hit = b_reg <= 0 && b_reg >= a_reg && c_reg <= 0 && c_reg >= a_reg;
        end
    end

    // dominant axis for collinear overlap
    always_comb begin
        if (magx_reg >= magy_reg) begin
            r0 = px;  r1 = pnx; s0 = qx; s1 = qnx;
        end else begin
            r0 = py;  r1 = pny; s0 = qy; s1 = qny;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fc_reg        <= '0;
            sc_reg        <= '0;
            ovf_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (take) begin
                if (cmd_kind == CMD_FIRST) begin
                    if (fc_reg < CNT_W'(MAX_VERTICES)) begin
                        fc_reg <= fc_reg + CNT_W'(1);
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end else begin
                    if (sc_reg < CNT_W'(MAX_VERTICES)) begin
                        sc_reg <= sc_reg + CNT_W'(1);
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
            end
            case (state_reg)
                ST_START: begin
                    hit_reg <= 1'b0;
                    i_reg   <= '0;
                    j_reg   <= '0;
                end
                ST_DECIDE: begin
                    hit_reg <= edge_hit;
                    if (j_more) begin
                        j_reg <= j_inc[IDX_W-1:0];
                    end else begin
                        j_reg <= '0;
                        i_reg <= in_idx;
                    end
                end
                ST_DONE: begin
                    out_valid_reg <= 1'b1;
                    fc_reg        <= '0;
                    sc_reg        <= '0;
                    ovf_reg       <= 1'b0;
                end
                default: begin
                    hit_reg <= hit_reg;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE) begin
            out_cross_reg <= hit_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    // vertex stores
    always_ff @(posedge aclk) begin
        if (take && cmd_kind == CMD_FIRST && fc_reg < CNT_W'(MAX_VERTICES)) begin
            first_mem[fc_reg[IDX_W-1:0]] <= cmd_xy;
        end
        if (take && cmd_kind != CMD_FIRST && sc_reg < CNT_W'(MAX_VERTICES)) begin
            second_mem[sc_reg[IDX_W-1:0]] <= cmd_xy;
        end
        if (rd_en) begin
            p_reg  <= first_mem[i_reg];
            pn_reg <= first_mem[in_idx];
            q_reg  <= second_mem[j_reg];
            qn_reg <= second_mem[jn_idx];
        end
    end

    // cross-product datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIFF) begin
            rx_reg  <= D'(pnx) - D'(px);
            ry_reg  <= D'(pny) - D'(py);
            sx_reg  <= D'(qnx) - D'(qx);
            sy_reg  <= D'(qny) - D'(qy);
            dqx_reg <= D'(qx) - D'(px);
            dqy_reg <= D'(qy) - D'(py);
        end
        if (state_reg == ST_MUL) begin
            m1_reg   <= ry_reg * sx_reg;
            m2_reg   <= rx_reg * sy_reg;
            m3_reg   <= rx_reg * dqy_reg;
            m4_reg   <= ry_reg * dqx_reg;
            m5_reg   <= sx_reg * dqy_reg;
            m6_reg   <= sy_reg * dqx_reg;
            magx_reg <= {1'b0, abs_d(rx_reg)} + {1'b0, abs_d(sx_reg)};
            magy_reg <= {1'b0, abs_d(ry_reg)} + {1'b0, abs_d(sy_reg)};
        end
        if (state_reg == ST_SUM) begin
            a_reg    <= S'(m1_reg) - S'(m2_reg);
            b_reg    <= S'(m3_reg) - S'(m4_reg);
            c_reg    <= S'(m5_reg) - S'(m6_reg);
            lo_r_reg <= (r0 < r1) ? r0 : r1;
            hi_r_reg <= (r0 > r1) ? r0 : r1;
            lo_s_reg <= (s0 < s1) ? s0 : s1;
            hi_s_reg <= (s0 > s1) ? s0 : s1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_ovf_reg, out_cross_reg};

endmodule

// ===== hdl/polygon_edge_crossing_test.sv =====
// Polygon edge crossing test. Load the first polygon's vertices (tuser = 0),
// then the second's (tuser = 1); tlast on the second polygon's last vertex
// starts the test and yields one result transaction. The engine takes queued
// vertices only while idle. The test walks edge pairs through a five-step
// read, subtract, multiply, sum and decide sequence, stopping early when a
// crossing is found; vertex stores are read through registered ports and
// have no reset. Vertices beyond MAX_VERTICES are dropped and flagged as
// overflow.
// Depends on pec_pkg, pec_front, pec_queue and pec_back.
module polygon_edge_crossing_test #(
    parameter int MAX_VERTICES = pec_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = pec_pkg::COORD_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // x [15:0], y [31:16]
    input  logic        s_tuser,   // func
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // crossing [0], overflow [1], zero fill
);
    import pec_pkg::*;

    localparam int QW = 2 * COORD_WIDTH + CMD_W;

    logic          push_valid, push_ready, pop_valid, pop_ready;
    logic [QW-1:0] push_data, pop_data;

    pec_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pec_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pec_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== tb/polygon_edge_crossing_test_checker.sv =====
// Checker for the polygon edge crossing test: watches both streams, predicts
// the crossing and overflow flags of each test and compares them.
// Depends on nothing but the ports of polygon_edge_crossing_test.
`timescale 1ns / 100ps
module polygon_edge_crossing_test_checker #(
    parameter int MAX_VERTICES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          fail_count,
    output int          pending_count
);
    typedef struct packed {
        logic crossing;
        logic overflow;
    } flags_t;

    longint ax[MAX_VERTICES], ay[MAX_VERTICES];
    longint bx[MAX_VERTICES], by[MAX_VERTICES];
    int     a_count, b_count;
    logic   dropped;
    flags_t expected_flags[$];

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint lo(longint a, longint b);
        return a < b ? a : b;
    endfunction

    function automatic longint hi(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic bit segments_meet(longint px, longint py, longint rx, longint ry,
                                         longint qx, longint qy, longint sx, longint sy);
        longint den, tn, un, r0, r1, s0, s1;
        den = ry * sx - rx * sy;
        tn  = rx * (qy - py) - ry * (qx - px);
        un  = sy * (px - qx) - sx * (py - qy);
        if (den == 0) begin
            if (tn != 0 && un != 0)
                return 0;
            // compare extents on the dominant axis, open bounds
            if (mag(rx) + mag(sx) >= mag(ry) + mag(sy)) begin
                r0 = px; r1 = px + rx; s0 = qx; s1 = qx + sx;
            end else begin
                r0 = py; r1 = py + ry; s0 = qy; s1 = qy + sy;
            end
            return hi(lo(r0, r1), lo(s0, s1)) < lo(hi(r0, r1), hi(s0, s1));
        end
        if (den > 0)
            return tn >= 0 && tn <= den && un >= 0 && un <= den;
        return tn <= 0 && tn >= den && un <= 0 && un >= den;
    endfunction

    function automatic bit outlines_cross(int na, int nb);
        int in, jn;
        for (int i = 0; i < na; i++) begin
            in = (i + 1 < na) ? i + 1 : 0;
            for (int j = 0; j < nb; j++) begin
                jn = (j + 1 < nb) ? j + 1 : 0;
                if (segments_meet(ax[i], ay[i], ax[in] - ax[i], ay[in] - ay[i],
                                  bx[j], by[j], bx[jn] - bx[j], by[jn] - by[j]))
                    return 1;
            end
        end
        return 0;
    endfunction

    assign pending_count = expected_flags.size();

    always @(posedge aclk) begin
        flags_t got, want;
        longint vx, vy;
        int     errs;
        errs = 0;
        if (!aresetn) begin
            a_count    <= 0;
            b_count    <= 0;
            dropped    <= 0;
            fail_count <= 0;
            expected_flags.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.crossing = m_tdata[0];
                got.overflow = m_tdata[1];
                if (expected_flags.size() == 0) begin
                    $error("unexpected result transaction %h", m_tdata);
                    errs++;
                end else begin
                    want = expected_flags.pop_front();
                    if (got.crossing !== want.crossing) begin
                        $error("crossing: expected %0d, actual %0d", want.crossing,
                               got.crossing);
                        errs++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("overflow: expected %0d, actual %0d", want.overflow,
                               got.overflow);
                        errs++;
                    end
                    if (m_tdata[7:2] !== 6'd0) begin
                        $error("fill: expected 0, actual %0h", m_tdata[7:2]);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                vx = longint'($signed(s_tdata[15:0]));
                vy = longint'($signed(s_tdata[31:16]));
                if (!s_tuser) begin
                    if (a_count < MAX_VERTICES) begin
                        ax[a_count] = vx;
                        ay[a_count] = vy;
                        a_count <= a_count + 1;
                    end else
                        dropped <= 1;
                end else begin
                    if (b_count < MAX_VERTICES) begin
                        bx[b_count] = vx;
                        by[b_count] = vy;
                    end
                    if (s_tlast) begin
                        // the last vertex counts when it still fits the store
                        want.crossing = outlines_cross(a_count,
                            (b_count < MAX_VERTICES) ? b_count + 1 : b_count);
                        want.overflow = dropped || (b_count >= MAX_VERTICES);
                        expected_flags.push_back(want);
                        a_count <= 0;
                        b_count <= 0;
                        dropped <= 0;
                    end else if (b_count < MAX_VERTICES)
                        b_count <= b_count + 1;
                    else
                        dropped <= 1;
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

// ===== tb/polygon_edge_crossing_test_tb.sv =====
// Testbench top for polygon_edge_crossing_test: drives polygon pairs with
// random gaps and stalls, the checker predicts and compares.
// Depends on pec_pkg, polygon_edge_crossing_test and its checker.
`timescale 1ns / 100ps
module polygon_edge_crossing_test_tb;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // x [15:0], y [31:16]
    logic        s_tuser = 0;    // func
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;        // crossing [0], overflow [1]
    int          fail_count, pending_count;
    int          sent;
    int          hold_left = 0;
    bit          calm;           // no idling in the last part
    bit          long_hold;

    localparam int VMAX = pec_pkg::MAX_VERTICES_DEF;

    always #6 aclk = ~aclk;

    polygon_edge_crossing_test dut (.*);

    polygon_edge_crossing_test_checker #(.MAX_VERTICES(VMAX)) u_checker (.*);

    task automatic send_vertex(bit second, logic [15:0] vx, logic [15:0] vy, bit tail);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= second;
        s_tdata  <= {vy, vx};
        s_tlast  <= tail;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    function automatic logic [15:0] pick_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    // pair of polygons; counts may exceed the store to exercise overflow
    task automatic send_pair(int n1, int n2, int mode);
        for (int i = 0; i < n1; i++)
            send_vertex(0, pick_coord(mode), pick_coord(mode), i == n1 - 1);
        for (int j = 0; j < n2; j++)
            send_vertex(1, pick_coord(mode), pick_coord(mode), j == n2 - 1);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // hold off the sink in random bursts
    always @(posedge aclk) begin
        if (long_hold) begin
            m_tready <= 0;
        end else if (hold_left > 0) begin
            m_tready  <= 0;
            hold_left <= hold_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_tready  <= 0;
            hold_left <= $urandom_range(0, 10);
        end else begin
            m_tready <= 1;
        end
    end

    initial begin
        int n1, n2;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: extremes, empty and single-vertex polygons, collinear, overflow
        send_vertex(1, 16'h7fff, 16'h8000, 1);
        send_vertex(0, 16'h0000, 16'h0000, 1);
        send_vertex(1, 16'h0000, 16'h0000, 1);
        send_vertex(0, 16'h8000, 16'h8000, 0);
        send_vertex(0, 16'h7fff, 16'h7fff, 1);
        send_vertex(1, 16'h8000, 16'h7fff, 0);
        send_vertex(1, 16'h7fff, 16'h8000, 1);
        send_vertex(0, 16'd0, 16'd0, 0);
        send_vertex(0, 16'd10, 16'd0, 1);
        send_vertex(1, 16'd5, 16'd0, 0);
        send_vertex(1, 16'd20, 16'd0, 1);
        send_vertex(0, 16'd0, 16'd0, 0);
        send_vertex(0, 16'd10, 16'd0, 1);
        send_vertex(1, 16'd10, 16'd0, 0);
        send_vertex(1, 16'd20, 16'd0, 1);
        send_vertex(0, 16'd0, 16'd0, 0);
        send_vertex(0, 16'd0, 16'd10, 1);
        send_vertex(1, 16'd0, 16'd5, 0);
        send_vertex(1, 16'd0, 16'd30, 1);
        send_pair(VMAX + 2, 3, 1);
        send_pair(2, VMAX + 1, 1);
        drain();
        // pause the sink while the source keeps pushing
        fork
            begin
                long_hold = 1;
                repeat (400) @(posedge aclk);
                long_hold = 0;
            end
            for (int k = 0; k < 6; k++) send_pair(2, 3, 1);
        join
        drain();
        while (sent < 1000) begin
            if (sent > 850) calm = 1;
            n1 = ($urandom_range(0, 19) == 0) ? $urandom_range(0, VMAX + 2)
                                              : $urandom_range(1, 6);
            n2 = ($urandom_range(0, 19) == 0) ? $urandom_range(1, VMAX + 2)
                                              : $urandom_range(1, 6);
            send_pair(n1, n2, $urandom_range(0, 2));
        end
        drain();
        repeat (2000) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
